@@ hw/rtl/rorp_pkg.sv @@
// shared constants, types and codes of the ring-ordered region planner
package rorp_pkg;

  localparam int TILES_PER_REGION = 64;
  localparam int MAX_REGION_COORD = 255;
  localparam int REGION_AXIS      = 256;
  localparam int MAX_PLAN_ENTRIES = 64;

  localparam int TILE_W  = 14;
  localparam int RAD_W   = 8;
  localparam int LIM_W   = 7;
  localparam int OUT_W   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int RC_W    = (MAX_REGION_COORD > 1) ? $clog2(MAX_REGION_COORD + 1) : 1;
  localparam int CNT_W   = $clog2(MAX_PLAN_ENTRIES + 1);
  localparam int AW      = TILE_W + 1;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SCENE_RADIUS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRELOAD_RADIUS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CPU_CHUNK_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GPU_CHUNK_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_CAPACITY = 3'd4;

  typedef struct packed {
    logic [RAD_W-1:0] scene_radius;
    logic [RAD_W-1:0] preload_radius;
    logic [LIM_W-1:0] cpu_chunk_limit;
    logic [LIM_W-1:0] gpu_chunk_limit;
    logic [LIM_W-1:0] output_capacity;
  } rorp_cfg_t;

  typedef struct packed {
    logic             err;
    logic [RC_W-1:0]  cx;
    logic [RC_W-1:0]  cy;
    logic [RC_W-1:0]  x0;
    logic [RC_W-1:0]  y0;
    logic [RC_W-1:0]  x1;
    logic [RC_W-1:0]  y1;
    logic [CNT_W-1:0] count;
  } rorp_job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ERR,
    BK_SCAN
  } bk_state_e;

endpackage

@@ hw/rtl/rorp_if.sv @@
// request and plan entry channel interfaces
interface rorp_in_if;
  logic                       valid;
  logic                       ready;
  logic [rorp_pkg::TILE_W-1:0] tile_col;
  logic [rorp_pkg::TILE_W-1:0] tile_row;

  modport source (output valid, output tile_col, output tile_row, input ready);
  modport sink   (input valid, input tile_col, input tile_row, output ready);
endinterface

interface rorp_out_if;
  logic                      valid;
  logic                      ready;
  logic [rorp_pkg::OUT_W-1:0] region_col;
  logic [rorp_pkg::OUT_W-1:0] region_row;
  logic                      plan_error;
  logic                      last_entry;

  modport source (output valid, output region_col, output region_row,
                  output plan_error, output last_entry, input ready);
  modport sink   (input valid, input region_col, input region_row,
                  input plan_error, input last_entry, output ready);
endinterface

@@ hw/rtl/rorp_front.sv @@
// request intake: center region, radius, box clipping and limit check
module rorp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  rorp_in_if.sink             in_ch,
  input  rorp_pkg::rorp_cfg_t cfg_i,
  output rorp_pkg::rorp_job_t job_o,
  output logic                job_valid_o,
  input  logic                job_ready_i
);
  import rorp_pkg::*;

  logic             a_valid_q, a_valid_d;
  logic             b_valid_q, b_valid_d;
  logic [TILE_W-1:0] cx_q, cy_q;
  logic [RAD_W-1:0]  rad_q;
  logic [LIM_W-1:0]  lim_q, lim_b_q;
  logic             err_b_q;
  logic [RC_W-1:0]  bcx_q, bcy_q, x0_q, y0_q, x1_q, y1_q;

  logic             acc, a_free, b_free;
  logic [LIM_W-1:0] lim_in, lim_t0, lim_t1;
  logic [RAD_W-1:0] rad_in;
  logic [AW-1:0]    cxw, cyw, rw, xlo, ylo, xsum, ysum, xhi, yhi;
  logic             err_a;
  logic [RC_W:0]    w, h;
  logic [2*RC_W+1:0] cnt;

  assign b_free      = !b_valid_q || job_ready_i;
  assign a_free      = !a_valid_q || b_free;
  assign in_ch.ready = a_free;
  assign acc         = in_ch.valid && a_free;

  // limit and radius from registers
  always_comb begin
    lim_t0 = (cfg_i.output_capacity < cfg_i.cpu_chunk_limit) ?
             cfg_i.output_capacity : cfg_i.cpu_chunk_limit;
    lim_t1 = (lim_t0 < cfg_i.gpu_chunk_limit) ? lim_t0 : cfg_i.gpu_chunk_limit;
    lim_in = (lim_t1 < LIM_W'(MAX_PLAN_ENTRIES)) ? lim_t1 : LIM_W'(MAX_PLAN_ENTRIES);
    rad_in = (cfg_i.scene_radius > cfg_i.preload_radius) ?
             cfg_i.scene_radius : cfg_i.preload_radius;
  end

  // clipping
  always_comb begin
    cxw   = AW'(cx_q);
    cyw   = AW'(cy_q);
    rw    = AW'(rad_q);
    xlo   = (cxw > rw) ? cxw - rw : '0;
    ylo   = (cyw > rw) ? cyw - rw : '0;
    xsum  = cxw + rw;
    ysum  = cyw + rw;
    xhi   = (xsum > AW'(MAX_REGION_COORD)) ? AW'(MAX_REGION_COORD) : xsum;
    yhi   = (ysum > AW'(MAX_REGION_COORD)) ? AW'(MAX_REGION_COORD) : ysum;
    err_a = (cxw > AW'(MAX_REGION_COORD)) || (cyw > AW'(MAX_REGION_COORD)) ||
            (rw >= AW'(REGION_AXIS)) || (lim_q == '0);
  end

  // box size
  always_comb begin
    w   = {1'b0, x1_q} - {1'b0, x0_q} + (RC_W+1)'(1);
    h   = {1'b0, y1_q} - {1'b0, y0_q} + (RC_W+1)'(1);
    cnt = (2*RC_W+2)'(w) * (2*RC_W+2)'(h);
  end

  always_comb begin
    job_o.err   = err_b_q || (cnt > (2*RC_W+2)'(lim_b_q));
    job_o.cx    = bcx_q;
    job_o.cy    = bcy_q;
    job_o.x0    = x0_q;
    job_o.y0    = y0_q;
    job_o.x1    = x1_q;
    job_o.y1    = y1_q;
    job_o.count = cnt[CNT_W-1:0];
  end
  assign job_valid_o = b_valid_q;

  always_comb begin
    a_valid_d = acc ? 1'b1 : (b_free ? 1'b0 : a_valid_q);
    b_valid_d = (a_valid_q && b_free) ? 1'b1 : (job_ready_i ? 1'b0 : b_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      b_valid_q <= b_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      cx_q  <= TILE_W'(in_ch.tile_col / TILES_PER_REGION);
      cy_q  <= TILE_W'(in_ch.tile_row / TILES_PER_REGION);
      rad_q <= rad_in;
      lim_q <= lim_in;
    end
    if (a_valid_q && b_free) begin
      err_b_q <= err_a;
      lim_b_q <= lim_q;
      bcx_q   <= cxw[RC_W-1:0];
      bcy_q   <= cyw[RC_W-1:0];
      x0_q    <= xlo[RC_W-1:0];
      y0_q    <= ylo[RC_W-1:0];
      x1_q    <= xhi[RC_W-1:0];
      y1_q    <= yhi[RC_W-1:0];
    end
  end

endmodule

@@ hw/rtl/rorp_queue.sv @@
// small job queue between intake and ring scan
module rorp_queue #(
  parameter int DEPTH = rorp_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rorp_pkg::rorp_job_t data_i,
  output logic                ready_o,
  output logic                valid_o,
  output rorp_pkg::rorp_job_t data_o,
  input  logic                pop_i
);
  import rorp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  rorp_job_t         mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              do_push, do_pop;

  assign ready_o = (fill_q != FILL_W'(DEPTH));
  assign valid_o = (fill_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d   = do_push ? ((wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1)) : wr_q;
    rd_d   = do_pop  ? ((rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1)) : rd_q;
    fill_d = fill_q + FILL_W'(do_push) - FILL_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

@@ hw/rtl/rorp_back.sv @@
// ring scan over the clipped box and plan entry output register
module rorp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  input  rorp_pkg::rorp_job_t job_i,
  output logic                job_pop_o,
  rorp_out_if.source          out_ch
);
  import rorp_pkg::*;

  bk_state_e        state_q, state_d;
  rorp_job_t        job_q;
  logic [RC_W-1:0]  x_q, y_q, dist_q;
  logic [CNT_W-1:0] emitted_q;
  logic             out_valid_q;
  logic [OUT_W-1:0] col_q, row_q;
  logic             err_q, last_q;

  logic             slot_free, hit, last_hit, emit, emit_err, step;
  logic [RC_W-1:0]  dx, dy, dmax;
  logic [RC_W+OUT_W-1:0] x_ext, y_ext;

  assign slot_free = !out_valid_q || out_ch.ready;

  always_comb begin
    dx       = (x_q > job_q.cx) ? x_q - job_q.cx : job_q.cx - x_q;
    dy       = (y_q > job_q.cy) ? y_q - job_q.cy : job_q.cy - y_q;
    dmax     = (dx > dy) ? dx : dy;
    hit      = (dmax == dist_q);
    last_hit = ({1'b0, emitted_q} + (CNT_W+1)'(1)) == {1'b0, job_q.count};
    x_ext    = (RC_W+OUT_W)'(x_q);
    y_ext    = (RC_W+OUT_W)'(y_q);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: if (job_valid_i) state_d = job_i.err ? BK_ERR : BK_SCAN;
      BK_ERR:  if (slot_free) state_d = BK_IDLE;
      BK_SCAN: if (hit && slot_free && last_hit) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop_o = 1'b0;
    emit      = 1'b0;
    emit_err  = 1'b0;
    step      = 1'b0;
    unique case (state_q)
      BK_IDLE: job_pop_o = job_valid_i;
      BK_ERR: begin
        emit     = slot_free;
        emit_err = 1'b1;
      end
      BK_SCAN: begin
        emit = hit && slot_free;
        step = !hit || slot_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q     <= job_i;
      x_q       <= job_i.x0;
      y_q       <= job_i.y0;
      dist_q    <= '0;
      emitted_q <= '0;
    end else if (step) begin
      if (x_q == job_q.x1) begin
        x_q <= job_q.x0;
        if (y_q == job_q.y1) begin
          y_q    <= job_q.y0;
          dist_q <= dist_q + RC_W'(1);
        end else begin
          y_q <= y_q + RC_W'(1);
        end
      end else begin
        x_q <= x_q + RC_W'(1);
      end
      if (emit) begin
        emitted_q <= emitted_q + CNT_W'(1);
      end
    end
    if (emit) begin
      col_q  <= emit_err ? '0 : x_ext[OUT_W-1:0];
      row_q  <= emit_err ? '0 : y_ext[OUT_W-1:0];
      err_q  <= emit_err;
      last_q <= emit_err || last_hit;
    end
  end

  assign out_ch.valid      = out_valid_q;
  assign out_ch.region_col = col_q;
  assign out_ch.region_row = row_q;
  assign out_ch.plan_error = err_q;
  assign out_ch.last_entry = last_q;

  a_emit_below_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_SCAN) |-> (emitted_q < job_q.count))
    else $error("scan emitted count reached job size");

  a_scan_in_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_SCAN) |-> (x_q >= job_q.x0 && x_q <= job_q.x1 &&
                              y_q >= job_q.y0 && y_q <= job_q.y1))
    else $error("scan position left the clipped box");

  a_error_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && err_q) |-> (last_q && col_q == '0 && row_q == '0))
    else $error("error entry not marked last or not zero");

  a_last_ends_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !emit_err && last_hit) |=> (state_q == BK_IDLE))
    else $error("scan continued past last entry");

endmodule

@@ hw/rtl/ring_ordered_region_planner.sv @@
// ring-ordered region planner top level: config registers, intake, queue, ring scan
//
//   channel  dir  handshake          payload
//   in_ch    in   valid/ready        tile_col[13:0], tile_row[13:0]
//   out_ch   out  valid/ready        region_col[7:0], region_row[7:0], plan_error, last_entry
//   cfg      in   cfg_we_i           cfg_idx_i[2:0], cfg_data_i[7:0]
//
// intake holds a request in stage A, then stage B, then it waits in a QUEUE_DEPTH-entry queue
// the ring scan visits one box cell per cycle while the output register takes entries, sweeping
// all box cells once per ring distance from 0 to maxdist; the job is popped first, in idle
// a rejected request holds the scan for the job pop and then the error entry
// reset clears the valid bits and loads register defaults, no clearing pass
// a full output register stalls the scan; a full queue stalls intake and in_ch.ready
module ring_ordered_region_planner #(
  parameter int QUEUE_DEPTH = rorp_pkg::QUEUE_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  rorp_in_if.sink                           in_ch,
  rorp_out_if.source                        out_ch,
  input  logic                              cfg_we_i,
  input  logic [rorp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rorp_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import rorp_pkg::*;

  rorp_cfg_t cfg_q, cfg_d;
  rorp_job_t f_job, q_job;
  logic      f_valid, q_ready, q_valid, q_pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SCENE_RADIUS:    cfg_d.scene_radius    = cfg_data_i[RAD_W-1:0];
        CFG_PRELOAD_RADIUS:  cfg_d.preload_radius  = cfg_data_i[RAD_W-1:0];
        CFG_CPU_CHUNK_LIMIT: cfg_d.cpu_chunk_limit = cfg_data_i[LIM_W-1:0];
        CFG_GPU_CHUNK_LIMIT: cfg_d.gpu_chunk_limit = cfg_data_i[LIM_W-1:0];
        CFG_OUTPUT_CAPACITY: cfg_d.output_capacity = cfg_data_i[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scene_radius    <= RAD_W'(1);
      cfg_q.preload_radius  <= RAD_W'(1);
      cfg_q.cpu_chunk_limit <= LIM_W'(64);
      cfg_q.gpu_chunk_limit <= LIM_W'(64);
      cfg_q.output_capacity <= LIM_W'(64);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rorp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .cfg_i       (cfg_q),
    .job_o       (f_job),
    .job_valid_o (f_valid),
    .job_ready_i (q_ready)
  );

  rorp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .data_i  (f_job),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .data_o  (q_job),
    .pop_i   (q_pop)
  );

  rorp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (q_job),
    .job_pop_o   (q_pop),
    .out_ch      (out_ch)
  );

endmodule
